/* rtl/tws_pkg.sv */
// shared types and constants for the top-three-with-position selector
package tws_pkg;

    localparam int KEEP      = 3;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CNT_W     = 2;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_W-1:0] MAX_COLS = 9'd256;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
    } t_entry;

    // one kept entry with its occupancy flag
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // what a cell hands to its lower-ranked neighbor
    typedef struct packed {
        logic  insert;
        t_slot slot;
    } t_link;

endpackage

/* rtl/tws_cell.sv */
// one rank cell of the insertion chain
module tws_cell
    import tws_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  logic   i_clear,
    input  t_entry i_new,
    input  t_link  i_prev,
    output t_link  o_link,
    output t_slot  o_next
);

    logic   r_valid;
    t_entry r_entry;
    logic   w_insert;
    t_slot  n_slot;

    // new word belongs at or above this rank; equal values keep the older one
    assign w_insert = !r_valid || ($signed(i_new.value) > $signed(r_entry.value));

    always_comb begin
        n_slot.valid = r_valid;
        n_slot.entry = r_entry;
        if (i_prev.insert) begin
            n_slot = i_prev.slot;
        end else if (w_insert) begin
            n_slot.valid = 1'b1;
            n_slot.entry = i_new;
        end
    end

    assign o_link.insert     = w_insert;
    assign o_link.slot.valid = r_valid;
    assign o_link.slot.entry = r_entry;
    assign o_next            = n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_clear ? 1'b0 : n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= n_slot.entry;
        end
    end

endmodule

/* rtl/tws_outq.sv */
// result shift queue that drains the ranked snapshot one word per cycle while words are popped
module tws_outq
    import tws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_slot            i_slots [KEEP],
    input  logic             i_pop,
    output logic             o_busy,
    output t_entry           o_head,
    output logic [CNT_W-1:0] o_rank,
    output logic             o_last
);

    t_entry           r_q [KEEP];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_rank;
    logic [CNT_W-1:0] w_fill;

    // occupied slots are always contiguous from the top rank
    always_comb begin
        w_fill = '0;
        for (int k = 0; k < KEEP; k++) begin
            w_fill = w_fill + CNT_W'(i_slots[k].valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rank <= '0;
        end else if (i_load) begin
            r_cnt  <= w_fill;
            r_rank <= '0;
        end else if (i_pop) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_rank <= r_rank + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < KEEP; k++) begin
                r_q[k] <= i_slots[k].entry;
            end
        end else if (i_pop) begin
            for (int k = 0; k < KEEP - 1; k++) begin
                r_q[k] <= r_q[k+1];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_head = r_q[0];
    assign o_rank = r_rank;
    assign o_last = (r_cnt == CNT_W'(1));

endmodule

/* rtl/top_three_with_position.sv */
// top level: streaming top-three selector with row and column tracking
// the results of a matrix appear in the cycle after its last word is taken
// throughput: one element word per cycle; results leave one word per cycle while the sink is ready
// a last word waits while results of the previous matrix are queued, unless the final one leaves
// reset: synchronous active-low; clears kept entries, position, queue; num_cols to 1
// no clearing pass after reset, the block is ready on the first cycle out of reset
module top_three_with_position
    import tws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // element stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [31:0] value (signed)
    input  logic                  i_s_tlast,   // last element of the matrix
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [31:0] top_value, [39:32] row,
                                               // [47:40] col, [49:48] rank, rest zero
    output logic                  o_m_tlast,   // last result of the run
    // column count register
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [CFG_W-1:0] r_num_cols;
    logic [CFG_W-1:0] w_eff_cols;
    logic [POS_W-1:0] r_cur_row;
    logic [POS_W-1:0] r_cur_col;
    logic [CFG_W-1:0] w_col_inc;

    logic   w_in_acc;
    logic   w_last_acc;
    logic   w_out_acc;
    t_entry w_new;
    t_link  w_links [KEEP+1];
    t_slot  w_next  [KEEP];

    logic             w_busy;
    t_entry           w_head;
    logic [CNT_W-1:0] w_rank;

    // config is always taken; the user must write it only while the block is idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_num_cols <= i_cfg_data;
        end
    end

    // zero acts as one column, anything above the maximum saturates
    always_comb begin
        if (r_num_cols == '0) begin
            w_eff_cols = CFG_W'(1);
        end else if (r_num_cols > MAX_COLS) begin
            w_eff_cols = MAX_COLS;
        end else begin
            w_eff_cols = r_num_cols;
        end
    end

    // a last word needs the result queue empty or emptying this cycle, other words always go in
    assign o_s_tready = !w_busy || !i_s_tlast || (o_m_tlast && i_m_tready);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_last_acc = w_in_acc && i_s_tlast;
    assign w_out_acc  = o_m_tvalid && i_m_tready;

    // row-major position of the incoming element
    assign w_col_inc = {1'b0, r_cur_col} + CFG_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else if (w_in_acc) begin
            if (i_s_tlast) begin
                r_cur_row <= '0;
                r_cur_col <= '0;
            end else if (w_col_inc >= w_eff_cols) begin
                // row counter wraps naturally at its width
                r_cur_col <= '0;
                r_cur_row <= r_cur_row + POS_W'(1);
            end else begin
                r_cur_col <= w_col_inc[POS_W-1:0];
            end
        end
    end

    assign w_new.value = $signed(i_s_tdata[VAL_W-1:0]);
    assign w_new.row   = r_cur_row;
    assign w_new.col   = r_cur_col;

    // head of the chain never receives a shifted entry
    assign w_links[0] = '0;

    // rank 0 at the head; each cell shifts its entry down when a larger value lands above
    for (genvar g = 0; g < KEEP; g++) begin : g_cell
        tws_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_in_acc),
            .i_clear (i_s_tlast),
            .i_new   (w_new),
            .i_prev  (w_links[g]),
            .o_link  (w_links[g+1]),
            .o_next  (w_next[g])
        );
    end

    // snapshot of the chain including the last element, drained in rank order
    // a load in the cycle that pops the final queued word takes priority over the pop
    tws_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_last_acc),
        .i_slots (w_next),
        .i_pop   (w_out_acc),
        .o_busy  (w_busy),
        .o_head  (w_head),
        .o_rank  (w_rank),
        .o_last  (o_m_tlast)
    );

    assign o_m_tvalid = w_busy;
    assign o_m_tdata  = {6'b0, w_rank, w_head.col, w_head.row, w_head.value};

endmodule

/* rtl/tws_checker.sv */
// port-level checks for the top-three selector, bound to the top level
module tws_checker
    import tws_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  i_s_tlast,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    // a pending result word is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("result word dropped before it was taken");

    // a taken last element always yields a rank-0 result next cycle
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=>
        (o_m_tvalid && o_m_tdata[49:48] == 2'd0))
        else $error("no top result after last element");

    // rank never reaches three
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[49:48] != 2'd3))
        else $error("rank out of range");

    // within a run the next result follows at the next rank
    a_rank_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=>
        (o_m_tvalid && o_m_tdata[49:48] == $past(o_m_tdata[49:48]) + 2'd1))
        else $error("result run broken or ranks out of order");

endmodule

bind top_three_with_position tws_checker u_tws_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
